// ===== sv/lzd_pkg.sv =====
// Shared types, constants and helpers of the LZ bitstream decompressor.
package lzd_pkg;

  localparam int unsigned WindowSizeDef = 4096;
  localparam int unsigned LanesDef      = 8;
  localparam int unsigned CmdDepth      = 4;
  localparam int unsigned LenW          = 9;
  localparam int unsigned OffW          = 12;

  typedef enum logic [4:0] {
    PH_DISC1, PH_DISC2, PH_TOKEN, PH_LIT, PH_B2, PH_B3, PH_B4, PH_LENBYTE,
    PH_MARKER, PH_LA, PH_LB, PH_LC, PH_RUN0, PH_RUN1, PH_RUN2, PH_RUN3,
    PH_RUNDATA, PH_O1, PH_O2, PH_O3, PH_O3B, PH_O4, PH_O5, PH_O6, PH_OLOW
  } phase_e;

  typedef enum logic [1:0] {
    CK_NONE, CK_BYTE, CK_COPY
  } cmd_kind_e;

  typedef enum logic {
    F_ACC, F_BITS
  } front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE, BK_RD, BK_WR
  } back_state_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [7:0]        data;
    logic [LenW-1:0]   len;
    logic [OffW-1:0]   off_m1;
    logic              done;
  } cmd_t;

  function automatic logic is_data_phase(phase_e ph);
    return (ph == PH_LIT) || (ph == PH_LENBYTE) || (ph == PH_RUNDATA) || (ph == PH_OLOW);
  endfunction

endpackage

// ===== sv/lz_bitstream_decompressor.sv =====
// Top level of the LZ bitstream decompressor: parser, command queue and copy engine.
// Each payload word is taken and classified by the parser, which then walks up to eight
// control bits and offers the command; it takes no new word until that command is accepted.
// A match byte costs the copy engine a history read, then a write back, which waits when a
// packed word must leave and the output register is held; a literal or raw byte is written
// straight from the idle state once the output register is free. A long match holds the
// engine, and the parser stalls once the four-entry command queue fills. Results leave
// packed up to LANES bytes per word; every input word yields at least one result word, the
// final one with tlast set. The history memory is not cleared after reset.
module lz_bitstream_decompressor import lzd_pkg::*; #(
  parameter int unsigned WINDOW_SIZE = WindowSizeDef,
  parameter int unsigned LANES       = LanesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // out_data[63:0], byte_count[67:64], zero fill
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // done_res
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] unpacked_len_q, packed_len_q;
  cmd_t        f_cmd, b_cmd;
  logic        f_valid, f_ready, b_valid, b_ready;
  logic [63:0] out_data;
  logic [3:0]  out_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unpacked_len_q <= '0;
      packed_len_q   <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i) packed_len_q <= cfg_data_i;
      else unpacked_len_q <= cfg_data_i;
    end
  end

  lzd_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_byte_i      (s_axis_tdata),
    .unpacked_len_i (unpacked_len_q),
    .packed_len_i   (packed_len_q),
    .cmd_o          (f_cmd),
    .cmd_valid_o    (f_valid),
    .cmd_ready_i    (f_ready)
  );

  lzd_cmd_fifo #(.Depth(CmdDepth)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_cmd_i   (f_cmd),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_cmd_o    (b_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready)
  );

  lzd_back #(.WindowSize(WINDOW_SIZE), .Lanes(LANES)) u_back (
    .clk_i,
    .rst_ni,
    .cmd_i       (b_cmd),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_data),
    .out_count_o (out_count),
    .out_last_o  (m_axis_tlast),
    .out_done_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {4'd0, out_count, out_data};

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[67:64] <= 4'(LANES)))
    else $error("byte count above lane count");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[67:64] == 4'd0) |-> m_axis_tlast)
    else $error("empty result word not marked last");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[67:64] == 4'd0) |-> (m_axis_tdata[63:0] == 64'd0))
    else $error("empty result word carries data");

endmodule

// ===== sv/lzd_front.sv =====
// Parser front end: takes payload words, walks the control bits, issues commands.
module lzd_front import lzd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic [31:0] unpacked_len_i,
  input  logic [31:0] packed_len_i,
  output cmd_t        cmd_o,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i
);

  front_state_e    fst_q, fst_d;
  phase_e          phase_q, phase_d;
  logic [7:0]      bitbuf_q, bitbuf_d;
  logic [3:0]      bits_left_q, bits_left_d;
  logic [LenW-1:0] plen_q, plen_d;
  logic [3:0]      ohigh_q, ohigh_d;
  logic [6:0]      runleft_q, runleft_d;
  logic [31:0]     produced_q, produced_d;
  logic [31:0]     consumed_q, consumed_d;
  logic            finished_q, finished_d;
  logic            enter_q, enter_d;
  logic            can_q, can_d;
  cmd_kind_e       kind_q, kind_d;
  logic [7:0]      byte_q, byte_d;
  logic [LenW-1:0] len_q, len_d;
  logic [OffW-1:0] offm1_q, offm1_d;

  always_comb begin
    phase_e          ph;
    logic            fin;
    logic [3:0]      bl;
    logic [LenW-1:0] pl;
    logic [3:0]      oh;
    logic [6:0]      rl;
    logic            bit_v;
    logic [LenW-1:0] n;
    logic [32:0]     sum;
    logic [6:0]      rl2;

    fst_d       = fst_q;
    phase_d     = phase_q;
    bitbuf_d    = bitbuf_q;
    bits_left_d = bits_left_q;
    plen_d      = plen_q;
    ohigh_d     = ohigh_q;
    runleft_d   = runleft_q;
    produced_d  = produced_q;
    consumed_d  = consumed_q;
    finished_d  = finished_q;
    enter_d     = enter_q;
    can_d       = can_q;
    kind_d      = kind_q;
    byte_d      = byte_q;
    len_d       = len_q;
    offm1_d     = offm1_q;
    n           = '0;
    sum         = '0;
    rl2         = '0;
    bit_v       = 1'b0;

    ph  = phase_q;
    fin = finished_q;
    bl  = bits_left_q;
    pl  = plen_q;
    oh  = ohigh_q;
    rl  = runleft_q;
    if (enter_q && !fin) begin
      if (can_q) ph = PH_TOKEN;
      else fin = 1'b1;
    end
    for (int i = 0; i < 8; i++) begin
      if (!fin && !is_data_phase(ph) && bl != 4'd0) begin
        bl    = bl - 4'd1;
        bit_v = bitbuf_q[bl[2:0]];
        case (ph)
          PH_DISC1: ph = PH_DISC2;
          PH_TOKEN: ph = bit_v ? PH_B2 : PH_LIT;
          PH_B2:    ph = bit_v ? PH_B3 : PH_LA;
          PH_B3: begin
            if (bit_v) begin
              ph = PH_B4;
            end else begin
              pl = LenW'(2);
              oh = 4'd0;
              ph = PH_OLOW;
            end
          end
          PH_B4: begin
            if (bit_v) begin
              ph = PH_LENBYTE;
            end else begin
              pl = LenW'(3);
              ph = PH_O1;
            end
          end
          PH_MARKER: begin
            if (!bit_v) fin = 1'b1;
            else if (can_q) ph = PH_TOKEN;
            else fin = 1'b1;
          end
          PH_LA: begin
            pl = LenW'(4) + LenW'(bit_v);
            ph = PH_LB;
          end
          PH_LB: ph = bit_v ? PH_LC : PH_O1;
          PH_LC: begin
            pl = ((pl - LenW'(1)) << 1) | LenW'(bit_v);
            ph = (pl == LenW'(9)) ? PH_RUN0 : PH_O1;
          end
          PH_RUN0: begin
            pl = LenW'(bit_v);
            ph = PH_RUN1;
          end
          PH_RUN1: begin
            pl = {pl[LenW-2:0], bit_v};
            ph = PH_RUN2;
          end
          PH_RUN2: begin
            pl = {pl[LenW-2:0], bit_v};
            ph = PH_RUN3;
          end
          PH_RUN3: begin
            pl = LenW'({pl[2:0], bit_v});
            rl = 7'((7'(pl[3:0]) + 7'd3) << 2);
            ph = PH_RUNDATA;
          end
          PH_O1: begin
            if (bit_v) begin
              ph = PH_O2;
            end else begin
              oh = 4'd0;
              ph = PH_OLOW;
            end
          end
          PH_O2: begin
            oh = 4'(bit_v);
            ph = PH_O3;
          end
          PH_O3: begin
            if (bit_v) ph = PH_O4;
            else ph = (oh == 4'd0) ? PH_O3B : PH_OLOW;
          end
          PH_O3B: begin
            oh = 4'(bit_v) + 4'd2;
            ph = PH_OLOW;
          end
          PH_O4: begin
            oh = {oh[2:0], bit_v} + 4'd4;
            ph = PH_O5;
          end
          PH_O5: ph = bit_v ? PH_OLOW : PH_O6;
          PH_O6: begin
            oh = {oh[2:0], bit_v};
            ph = PH_OLOW;
          end
          default: begin
            if (can_q) ph = PH_TOKEN;
            else fin = 1'b1;
          end
        endcase
      end
    end

    in_ready_o  = (fst_q == F_ACC);
    cmd_valid_o = (fst_q == F_BITS);
    cmd_o.kind   = kind_q;
    cmd_o.data   = byte_q;
    cmd_o.len    = len_q;
    cmd_o.off_m1 = offm1_q;
    cmd_o.done   = fin;

    case (fst_q)
      F_ACC: begin
        if (in_valid_i) begin
          fst_d   = F_BITS;
          kind_d  = CK_NONE;
          enter_d = 1'b0;
          byte_d  = in_byte_i;
          if (!finished_q) begin
            consumed_d = (consumed_q == '1) ? consumed_q : consumed_q + 32'd1;
            if (is_data_phase(phase_q)) begin
              case (phase_q)
                PH_LIT: begin
                  kind_d  = CK_BYTE;
                  n       = LenW'(1);
                  enter_d = 1'b1;
                end
                PH_LENBYTE: begin
                  if (in_byte_i == 8'd0) begin
                    phase_d = PH_MARKER;
                  end else begin
                    plen_d  = LenW'(in_byte_i) + LenW'(8);
                    phase_d = PH_O1;
                  end
                end
                PH_RUNDATA: begin
                  kind_d    = CK_BYTE;
                  n         = LenW'(1);
                  rl2       = (runleft_q != 7'd0) ? runleft_q - 7'd1 : 7'd0;
                  runleft_d = rl2;
                  enter_d   = (rl2 == 7'd0);
                end
                default: begin
                  kind_d  = CK_COPY;
                  len_d   = plen_q;
                  offm1_d = {ohigh_q, in_byte_i};
                  n       = plen_q;
                  enter_d = 1'b1;
                end
              endcase
            end else begin
              bitbuf_d    = in_byte_i;
              bits_left_d = 4'd8;
            end
            sum        = {1'b0, produced_q} + 33'(n);
            produced_d = sum[32] ? '1 : sum[31:0];
            can_d      = (produced_d < unpacked_len_i) && (consumed_d < packed_len_i);
          end
        end
      end
      F_BITS: begin
        if (cmd_ready_i) begin
          fst_d       = F_ACC;
          phase_d     = ph;
          finished_d  = fin;
          bits_left_d = bl;
          plen_d      = pl;
          ohigh_d     = oh;
          runleft_d   = rl;
          enter_d     = 1'b0;
        end
      end
      default: fst_d = F_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fst_q       <= F_ACC;
      phase_q     <= PH_DISC1;
      bitbuf_q    <= '0;
      bits_left_q <= '0;
      plen_q      <= '0;
      ohigh_q     <= '0;
      runleft_q   <= '0;
      produced_q  <= '0;
      consumed_q  <= '0;
      finished_q  <= 1'b0;
      enter_q     <= 1'b0;
      can_q       <= 1'b0;
      kind_q      <= CK_NONE;
    end else begin
      fst_q       <= fst_d;
      phase_q     <= phase_d;
      bitbuf_q    <= bitbuf_d;
      bits_left_q <= bits_left_d;
      plen_q      <= plen_d;
      ohigh_q     <= ohigh_d;
      runleft_q   <= runleft_d;
      produced_q  <= produced_d;
      consumed_q  <= consumed_d;
      finished_q  <= finished_d;
      enter_q     <= enter_d;
      can_q       <= can_d;
      kind_q      <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    len_q   <= len_d;
    offm1_q <= offm1_d;
  end

endmodule

// ===== sv/lzd_cmd_fifo.sv =====
// Short command queue between the parser and the copy engine.
module lzd_cmd_fifo import lzd_pkg::*; #(
  parameter int unsigned Depth = CmdDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t push_cmd_i,
  input  logic push_valid_i,
  output logic push_ready_o,
  output cmd_t pop_cmd_o,
  output logic pop_valid_o,
  input  logic pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    if (pop)  rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    if (push && !pop) cnt_d = cnt_q + CntW'(1);
    else if (pop && !push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_cmd_i;
  end

endmodule

// ===== sv/lzd_back.sv =====
// Copy engine: history window, match copy, lane packing and output register.
module lzd_back import lzd_pkg::*; #(
  parameter int unsigned WindowSize = WindowSizeDef,
  parameter int unsigned Lanes      = LanesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_data_o,
  output logic [3:0]  out_count_o,
  output logic        out_last_o,
  output logic        out_done_o
);

  localparam int unsigned AddrW = $clog2(WindowSize);
  localparam int unsigned CntW  = $clog2(Lanes + 1);

  back_state_e      bst_q, bst_d;
  logic [7:0]       hist_q [WindowSize];
  logic [7:0]       rd_q;
  logic             re, we;
  logic [AddrW-1:0] ra;
  logic [7:0]       wdata;
  logic [AddrW-1:0] wp_q, wp_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [OffW-1:0]  off_q, off_d;
  logic             done_q, done_d;
  logic [7:0]       acc_q [Lanes];
  logic [7:0]       acc_d [Lanes];
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             ov_q, ov_d;
  logic [63:0]      od_q, od_d;
  logic [3:0]       oc_q, oc_d;
  logic             ol_q, ol_d;
  logic             odn_q, odn_d;
  logic             out_free;

  assign out_free    = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign out_count_o = oc_q;
  assign out_last_o  = ol_q;
  assign out_done_o  = odn_q;

  always_comb begin
    logic [63:0] word;

    bst_d = bst_q;
    wp_d  = wp_q;
    rem_d = rem_q;
    off_d = off_q;
    done_d = done_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    ov_d  = ov_q;
    od_d  = od_q;
    oc_d  = oc_q;
    ol_d  = ol_q;
    odn_d = odn_q;
    re    = 1'b0;
    we    = 1'b0;
    ra    = wp_q - AddrW'(off_q) - AddrW'(1);
    wdata = rd_q;
    cmd_ready_o = 1'b0;
    word  = '0;

    if (ov_q && out_ready_i) ov_d = 1'b0;

    case (bst_q)
      BK_IDLE: begin
        cmd_ready_o = out_free;
        if (cmd_valid_i && out_free) begin
          case (cmd_i.kind)
            CK_BYTE: begin
              we    = 1'b1;
              wdata = cmd_i.data;
              wp_d  = wp_q + AddrW'(1);
              ov_d  = 1'b1;
              od_d  = {56'd0, cmd_i.data};
              oc_d  = 4'd1;
              ol_d  = 1'b1;
              odn_d = cmd_i.done;
            end
            CK_COPY: begin
              rem_d  = cmd_i.len;
              off_d  = cmd_i.off_m1;
              done_d = cmd_i.done;
              cnt_d  = '0;
              bst_d  = BK_RD;
            end
            default: begin
              ov_d  = 1'b1;
              od_d  = '0;
              oc_d  = 4'd0;
              ol_d  = 1'b1;
              odn_d = cmd_i.done;
            end
          endcase
        end
      end
      BK_RD: begin
        re    = 1'b1;
        bst_d = BK_WR;
      end
      BK_WR: begin
        if (rem_q != LenW'(1) && cnt_q != CntW'(Lanes - 1)) begin
          for (int l = 0; l < Lanes; l++) begin
            if (cnt_q == CntW'(l)) acc_d[l] = rd_q;
          end
          cnt_d = cnt_q + CntW'(1);
          we    = 1'b1;
          wp_d  = wp_q + AddrW'(1);
          rem_d = rem_q - LenW'(1);
          bst_d = BK_RD;
        end else if (out_free) begin
          for (int l = 0; l < Lanes; l++) begin
            word[l*8 +: 8] = (cnt_q == CntW'(l)) ? rd_q : acc_q[l];
            acc_d[l] = '0;
          end
          ov_d  = 1'b1;
          od_d  = word;
          oc_d  = 4'(cnt_q) + 4'd1;
          ol_d  = (rem_q == LenW'(1));
          odn_d = done_q;
          cnt_d = '0;
          we    = 1'b1;
          wp_d  = wp_q + AddrW'(1);
          rem_d = rem_q - LenW'(1);
          bst_d = (rem_q == LenW'(1)) ? BK_IDLE : BK_RD;
        end
      end
      default: bst_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bst_q <= BK_IDLE;
      wp_q  <= '0;
      rem_q <= '0;
      cnt_q <= '0;
      ov_q  <= 1'b0;
      for (int l = 0; l < Lanes; l++) acc_q[l] <= '0;
    end else begin
      bst_q <= bst_d;
      wp_q  <= wp_d;
      rem_q <= rem_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q  <= off_d;
    done_q <= done_d;
    od_q   <= od_d;
    oc_q   <= oc_d;
    ol_q   <= ol_d;
    odn_q  <= odn_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) hist_q[wp_q] <= wdata;
    if (re) rd_q <= hist_q[ra];
  end

endmodule

// ===== bench/tb.sv =====
// Stream-level testbench of the LZ bitstream decompressor with a built-in bit-exact predictor.
module tb;
  import lzd_pkg::*;

  typedef struct {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic        done;
  } out_word_t;

  localparam int unsigned CycleLimit = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [31:0] cfg_data_i = 32'h0;

  lz_bitstream_decompressor dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // predictor state
  logic [31:0] unpacked_len, packed_len;
  logic [7:0]  bitbuf;
  logic [3:0]  bitcnt;
  phase_e      phase;
  logic [8:0]  plen;
  logic [3:0]  off_hi;
  logic [6:0]  run_left;
  logic [31:0] produced, consumed;
  logic [7:0]  history [4096];
  logic [11:0] wr_ptr;
  logic        finished;
  logic [7:0]  step_bytes [$];

  out_word_t   expected_words_q [$];
  int          errors = 0;
  int unsigned cycles = 0;
  bit          calm = 0;

  // stream encoder state
  logic [7:0]  stream_q [$];
  int          ctl_pos = -1;
  int          ctl_left = 0;
  int unsigned enc_produced = 0;
  int unsigned sent = 0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  task automatic emit_byte(logic [7:0] b);
    history[wr_ptr] = b;
    wr_ptr++;
    produced = sat_inc(produced);
    step_bytes.insert(step_bytes.size(), b);
  endtask

  task automatic start_token();
    if (produced < unpacked_len && consumed < packed_len) phase = PH_TOKEN;
    else finished = 1'b1;
  endtask

  function automatic bit data_phase(phase_e ph);
    return ph inside {PH_LIT, PH_LENBYTE, PH_RUNDATA, PH_OLOW};
  endfunction

  task automatic parse_bit(logic bt);
    case (phase)
      PH_DISC1: phase = PH_DISC2;
      PH_DISC2: start_token();
      PH_TOKEN: phase = bt ? PH_B2 : PH_LIT;
      PH_B2:    phase = bt ? PH_B3 : PH_LA;
      PH_B3: begin
        if (bt) phase = PH_B4;
        else begin
          plen = 9'd2; off_hi = 4'd0; phase = PH_OLOW;
        end
      end
      PH_B4: begin
        if (bt) phase = PH_LENBYTE;
        else begin
          plen = 9'd3; phase = PH_O1;
        end
      end
      PH_MARKER: begin
        if (bt) start_token();
        else finished = 1'b1;
      end
      PH_LA: begin
        plen = 9'd4 + 9'(bt); phase = PH_LB;
      end
      PH_LB: phase = bt ? PH_LC : PH_O1;
      PH_LC: begin
        plen = 9'((plen - 9'd1) * 2 + bt);
        phase = (plen == 9'd9) ? PH_RUN0 : PH_O1;
      end
      PH_RUN0: begin
        plen = 9'(bt); phase = PH_RUN1;
      end
      PH_RUN1: begin
        plen = 9'(plen * 2 + bt); phase = PH_RUN2;
      end
      PH_RUN2: begin
        plen = 9'(plen * 2 + bt); phase = PH_RUN3;
      end
      PH_RUN3: begin
        plen = 9'((plen * 2 + bt) & 15);
        run_left = 7'((plen + 9'd3) * 4);
        phase = PH_RUNDATA;
      end
      PH_O1: begin
        if (bt) phase = PH_O2;
        else begin
          off_hi = 4'd0; phase = PH_OLOW;
        end
      end
      PH_O2: begin
        off_hi = 4'(bt); phase = PH_O3;
      end
      PH_O3: begin
        if (bt) phase = PH_O4;
        else phase = (off_hi == 4'd0) ? PH_O3B : PH_OLOW;
      end
      PH_O3B: begin
        off_hi = 4'(bt) + 4'd2; phase = PH_OLOW;
      end
      PH_O4: begin
        off_hi = 4'(off_hi * 2 + 4 + bt); phase = PH_O5;
      end
      PH_O5: phase = bt ? PH_OLOW : PH_O6;
      PH_O6: begin
        off_hi = 4'(off_hi * 2 + bt); phase = PH_OLOW;
      end
      default: start_token();
    endcase
  endtask

  task automatic parse_data(logic [7:0] b);
    logic [12:0] back_dist;
    logic [11:0] idx;
    case (phase)
      PH_LIT: begin
        emit_byte(b); start_token();
      end
      PH_LENBYTE: begin
        if (b == 8'd0) phase = PH_MARKER;
        else begin
          plen = 9'(b) + 9'd8; phase = PH_O1;
        end
      end
      PH_RUNDATA: begin
        emit_byte(b);
        if (run_left > 0) run_left--;
        if (run_left == 0) start_token();
      end
      default: begin
        back_dist = 13'({off_hi, b}) + 13'd1;
        for (int k = 0; k < plen; k++) begin
          idx = 12'(wr_ptr - back_dist);
          emit_byte(history[idx]);
        end
        start_token();
      end
    endcase
  endtask

  task automatic predict_byte(logic [7:0] b);
    out_word_t w;
    int        nres;
    step_bytes.delete();
    if (!finished) begin
      consumed = sat_inc(consumed);
      if (data_phase(phase)) parse_data(b);
      else begin
        bitbuf = b; bitcnt = 4'd8;
      end
      while (!finished && !data_phase(phase) && bitcnt > 0) begin
        bitcnt--;
        parse_bit(bitbuf[bitcnt]);
      end
    end
    nres = (step_bytes.size() == 0) ? 1 : (step_bytes.size() + 7) / 8;
    for (int r = 0; r < nres; r++) begin
      w.data = '0;
      w.count = '0;
      for (int i = 0; i < 8; i++) begin
        if (r * 8 + i < step_bytes.size()) begin
          w.data[8*i +: 8] = step_bytes[r * 8 + i];
          w.count++;
        end
      end
      w.last = (r + 1 == nres);
      w.done = finished;
      expected_words_q.insert(expected_words_q.size(), w);
    end
  endtask

  // encoder: control bytes are reserved where the parser will need a new bit
  task automatic put_bit(logic bt);
    if (ctl_left == 0) begin
      stream_q.insert(stream_q.size(), 8'($urandom));
      ctl_pos = stream_q.size() - 1;
      ctl_left = 8;
    end
    ctl_left--;
    stream_q[ctl_pos][ctl_left] = bt;
  endtask

  task automatic put_data(logic [7:0] b);
    stream_q.insert(stream_q.size(), b);
  endtask

  task automatic put_offset(int unsigned back_dist);
    int unsigned hi, v;
    hi = (back_dist - 1) >> 8;
    if (hi == 0) put_bit(0);
    else if (hi == 1) begin
      put_bit(1); put_bit(1); put_bit(0);
    end else if (hi < 4) begin
      put_bit(1); put_bit(0); put_bit(0); put_bit(hi[0]);
    end else if (hi < 8) begin
      put_bit(1); put_bit(hi[1]); put_bit(1); put_bit(hi[0]); put_bit(1);
    end else begin
      v = hi >> 1;
      put_bit(1); put_bit(v[1]); put_bit(1); put_bit(v[0]); put_bit(0); put_bit(hi[0]);
    end
    put_data(8'(back_dist - 1));
  endtask

  task automatic tok_literal(logic [7:0] b);
    put_bit(0); put_data(b);
    enc_produced++;
  endtask

  task automatic tok_match(int unsigned len, int unsigned back_dist);
    put_bit(1);
    if (len == 2) begin
      put_bit(1); put_bit(0); put_data(8'(back_dist - 1));
    end else begin
      if (len == 3) begin
        put_bit(1); put_bit(1); put_bit(0);
      end else if (len <= 5) begin
        put_bit(0); put_bit(len == 5); put_bit(0);
      end else if (len <= 8) begin
        put_bit(0); put_bit(len == 8); put_bit(1); put_bit(len == 7);
      end else begin
        put_bit(1); put_bit(1); put_bit(1); put_data(8'(len - 8));
      end
      put_offset(back_dist);
    end
    enc_produced += len;
  endtask

  task automatic tok_run(logic [3:0] n);
    put_bit(1); put_bit(0); put_bit(1); put_bit(1); put_bit(1);
    for (int i = 3; i >= 0; i--) put_bit(n[i]);
    for (int i = 0; i < (n + 3) * 4; i++) put_data(8'($urandom));
    enc_produced += (n + 3) * 4;
  endtask

  task automatic tok_marker(logic cont);
    put_bit(1); put_bit(1); put_bit(1); put_bit(1); put_data(8'h00); put_bit(cont);
  endtask

  task automatic tok_random_match();
    int unsigned len, reach;
    case ($urandom_range(0, 5))
      0: len = 2;
      1: len = 3;
      2, 3: len = $urandom_range(4, 8);
      4: len = $urandom_range(9, 40);
      default: len = ($urandom_range(0, 3) == 0) ? 263 : $urandom_range(9, 263);
    endcase
    reach = (len == 2) ? 256 : 4096;
    if (enc_produced < reach) reach = enc_produced;
    if ($urandom_range(0, 3) == 0) tok_match(len, reach);
    else tok_match(len, $urandom_range(1, reach));
  endtask

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_byte(b);
    sent++;
  endtask

  // send everything before a control byte that still has bits to fill
  task automatic flush_stream();
    int n;
    n = (ctl_left > 0) ? ctl_pos : stream_q.size();
    for (int i = 0; i < n; i++) send_byte(stream_q.pop_front());
    ctl_pos -= n;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_words_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == 1'b0) unpacked_len = val;
    else packed_len = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_tokens(int unsigned nbytes);
    int unsigned start;
    start = sent + stream_q.size();
    while (sent + stream_q.size() < start + nbytes) begin
      case ($urandom_range(0, 9))
        0, 1, 2: tok_literal(8'($urandom));
        3:       tok_run(4'($urandom));
        4:       tok_marker(1'b1);
        default: tok_random_match();
      endcase
      flush_stream();
    end
  endtask

  task automatic test_directed_tokens();
    write_reg(1'b0, 32'hFFFF_FFFF);
    write_reg(1'b1, 32'hFFFF_FFFF);
    put_bit(1); put_bit(0);
    tok_literal(8'h00);
    tok_literal(8'hFF);
    tok_match(2, 1);
    tok_match(3, 2);
    for (int l = 4; l <= 8; l++) tok_match(l, 3);
    tok_marker(1'b1);
    tok_run(4'd0);
    tok_match(9, 1);
    tok_match(263, 12);
    tok_run(4'd15);
    tok_match(263, 300);
    tok_match(100, 520);
    tok_match(50, 1000);
    tok_match(20, 2100);
    tok_match(10, 4096);
    flush_stream();
  endtask

  task automatic test_random_stream();
    random_tokens(70);
  endtask

  task automatic test_limit_update();
    wait_drained();
    write_reg(1'b0, 32'h8000_0000 | $urandom);
    write_reg(1'b1, 32'h8000_0000 | $urandom);
    random_tokens(60);
    wait_drained();
    write_reg(1'b1, 32'hFFFF_FFFF);
  endtask

  task automatic test_end_marker();
    calm = 1;
    random_tokens(30);
    tok_marker(1'b0);
    ctl_left = 0;
    flush_stream();
  endtask

  task automatic test_after_finish();
    wait_drained();
    write_reg(1'b0, 32'h0);
    write_reg(1'b1, 32'h0);
    for (int i = 0; i < 8; i++) send_byte(8'($urandom));
  endtask

  always @(negedge clk_i) begin : ready_gen
    int stall;
    if (calm) m_axis_tready <= 1'b1;
    else if (stall > 0) begin
      m_axis_tready <= 1'b0;
      stall--;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall = $urandom_range(0, 10);
    end else m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin : check_out
    out_word_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words_q.size() == 0)
        report_mismatch("unexpected word", m_axis_tdata[63:0], 64'd0);
      else begin
        w = expected_words_q.pop_front();
        if (m_axis_tdata[63:0] !== w.data) report_mismatch("out_data", m_axis_tdata[63:0], w.data);
        if (m_axis_tdata[67:64] !== w.count)
          report_mismatch("byte_count", 64'(m_axis_tdata[67:64]), 64'(w.count));
        if (m_axis_tlast !== w.last) report_mismatch("last", 64'(m_axis_tlast), 64'(w.last));
        if (m_axis_tuser !== w.done)
          report_mismatch("done_res", 64'(m_axis_tuser), 64'(w.done));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    unpacked_len = '0; packed_len = '0; bitbuf = '0; bitcnt = '0; phase = PH_DISC1;
    plen = '0; off_hi = '0; run_left = '0; produced = '0; consumed = '0;
    wr_ptr = '0; finished = 1'b0;
    foreach (history[i]) history[i] = 8'h00;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_tokens();
    test_random_stream();
    test_limit_update();
    test_end_marker();
    test_after_finish();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_words_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_words_q.size() == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
sv/lzd_pkg.sv
sv/lzd_front.sv
sv/lzd_cmd_fifo.sv
sv/lzd_back.sv
sv/lz_bitstream_decompressor.sv
bench/tb.sv
